### sv/fifo_and_richest_first_queue_assert.svh
// Assertion macros for the waiting-table block.
// Depends on: nothing. The using module must have i_clk and i_rst_n.
`ifndef FIFO_AND_RICHEST_FIRST_QUEUE_ASSERT_SVH
`define FIFO_AND_RICHEST_FIRST_QUEUE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define FRQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FRQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/frq_pkg.sv
// Shared types, constants and helpers for the waiting-table block.
// Depends on: nothing.
package frq_pkg;

    // Table size and sequence-number width
    localparam int CAPACITY    = 256;
    localparam int NUMBER_BITS = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int AMT_W       = 24;
    localparam int OUT_W       = 32;

    // Request codes
    localparam logic [1:0] REQ_ARRIVE  = 2'd0;
    localparam logic [1:0] REQ_OLDEST  = 2'd1;
    localparam logic [1:0] REQ_RICHEST = 2'd2;

    // Status codes
    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_SERVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [NUMBER_BITS-1:0] t_num;
    typedef logic [AMT_W-1:0]       t_amt;

    typedef struct packed {
        logic [1:0] req_type;
        t_amt       amount;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [OUT_W-1:0] served_number;
    } t_out_item;

    // One table slot as held in the RAM
    typedef struct packed {
        t_amt amount;
        t_num number;
    } t_entry;

    // Scan control from the sequencer to the best-candidate tracker
    typedef struct packed {
        logic clear;
        logic live;
        logic richest;
        logic cand_vld;
        t_idx cand_idx;
    } t_scan_ctl;

    // Result of a scan
    typedef struct packed {
        logic found;
        t_idx slot;
        t_num number;
    } t_best;

    // Next slot, going round the table
    function automatic t_idx next_slot(input t_idx s);
        return (s == IDX_W'(CAPACITY - 1)) ? '0 : s + IDX_W'(1);
    endfunction

endpackage

### sv/frq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on: nothing.
module frq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/frq_best.sv
// Best-candidate tracker: keeps the oldest or richest valid slot seen in a scan.
// Depends on: frq_pkg.
module frq_best import frq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    input  t_entry    i_cand,
    output t_best     o_best
);

    logic r_found;
    t_idx r_slot;
    t_amt r_amount;
    t_num r_number;
    logic n_take;
    logic n_better;

    // Ordering: richest first with oldest on a tie, or oldest only
    always_comb begin
        if (i_ctl.richest) begin
            n_better = (i_cand.amount > r_amount) ||
                       ((i_cand.amount == r_amount) && (i_cand.number < r_number));
        end else begin
            n_better = i_cand.number < r_number;
        end
        n_take = i_ctl.live && i_ctl.cand_vld && (!r_found || n_better);
    end

    // found flag is control; the rest is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (n_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_take) begin
            r_slot   <= i_ctl.cand_idx;
            r_amount <= i_cand.amount;
            r_number <= i_cand.number;
        end
    end

    assign o_best = '{found: r_found, slot: r_slot, number: r_number};

endmodule

### sv/fifo_and_richest_first_queue.sv
// Waiting table with oldest-first and richest-first service.
// Input channel i_in (valid/ready) takes one request item: arrival, serve oldest
// or serve richest. Output channel o_out (valid/ready) returns one status item
// per request, in request order.
// One request is worked on at a time. An arrival searches the valid marks for a
// free slot from the tail, one slot per cycle. A serve reads every slot of the
// entry RAM through its single read port, one per cycle. Refused and empty cases
// go straight to the finish state.
// Reset clears all valid marks, the fill count, the tail and the number counter
// (which restarts at 1) at once; no clearing pass is needed.
// A finished result sits in an output register, so the next request is taken
// while it waits. If the receiver stalls and a second result is finished, the
// block holds it and takes no further request until the register frees.
// Depends on: frq_pkg, frq_ram, frq_best, fifo_and_richest_first_queue_assert.svh.
module fifo_and_richest_first_queue import frq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    `include "fifo_and_richest_first_queue_assert.svh"

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SERVE = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]          r_state,    n_state;
    logic [CAPACITY-1:0] r_valid,    n_valid;
    t_cnt                r_count,    n_count;
    t_num                r_next_num, n_next_num;
    t_idx                r_tail,     n_tail;
    t_idx                r_idx,      n_idx;
    logic                r_richest,  n_richest;
    t_amt                r_amount,   n_amount;
    logic                r_live,     n_live;
    logic                r_cand_vld, n_cand_vld;
    t_idx                r_cand_idx, n_cand_idx;
    t_out_item           r_res,      n_res;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out,      n_out;

    logic      ram_we;
    t_entry    ram_wdata;
    t_entry    ram_rdata;
    t_scan_ctl scan_ctl;
    t_best     best;
    logic      in_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Entry store: amount and sequence number per slot
    frq_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(CAPACITY)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_idx),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx),
        .o_rdata(ram_rdata)
    );

    frq_best u_best (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (scan_ctl),
        .i_cand (ram_rdata),
        .o_best (best)
    );

    // Read data of a slot issued last cycle is judged this cycle
    always_comb begin
        scan_ctl.clear    = in_acc;
        scan_ctl.live     = r_live;
        scan_ctl.richest  = r_richest;
        scan_ctl.cand_vld = r_cand_vld;
        scan_ctl.cand_idx = r_cand_idx;
    end

    assign ram_wdata = '{amount: r_amount, number: r_next_num};

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_count     = r_count;
        n_next_num  = r_next_num;
        n_tail      = r_tail;
        n_idx       = r_idx;
        n_richest   = r_richest;
        n_amount    = r_amount;
        n_live      = 1'b0;
        n_cand_vld  = r_cand_vld;
        n_cand_idx  = r_cand_idx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;

        // Output register frees when taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res = '{status: ST_EMPTY, served_number: '0};
                    unique case (i_in.req_type)
                        REQ_ARRIVE: begin
                            if (r_count >= CNT_W'(CAPACITY) || r_next_num == '0) begin
                                n_res   = '{status: ST_REFUSED, served_number: '0};
                                n_state = S_FIN;
                            end else begin
                                n_idx    = r_tail;
                                n_amount = i_in.amount;
                                n_state  = S_ALLOC;
                            end
                        end
                        REQ_OLDEST, REQ_RICHEST: begin
                            n_richest = (i_in.req_type == REQ_RICHEST);
                            if (r_count == '0) begin
                                n_state = S_FIN;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            // Walk the valid marks from the tail to the first free slot
            S_ALLOC: begin
                if (!r_valid[r_idx]) begin
                    ram_we           = 1'b1;
                    n_valid[r_idx]   = 1'b1;
                    n_count          = r_count + CNT_W'(1);
                    n_next_num       = r_next_num + NUMBER_BITS'(1);
                    n_tail           = next_slot(r_idx);
                    n_res            = '{status: ST_STORED, served_number: OUT_W'(r_next_num)};
                    n_state          = S_FIN;
                end else begin
                    n_idx = next_slot(r_idx);
                end
            end
            // Issue one RAM read per cycle over the whole table
            S_SCAN: begin
                n_live     = 1'b1;
                n_cand_idx = r_idx;
                n_cand_vld = r_valid[r_idx];
                if (r_idx == IDX_W'(CAPACITY - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            // Last slot is judged this cycle
            S_DRAIN: begin
                n_state = S_SERVE;
            end
            S_SERVE: begin
                n_valid[best.slot] = 1'b0;
                n_count            = r_count - CNT_W'(1);
                n_res              = '{status: ST_SERVED, served_number: OUT_W'(best.number)};
                n_state            = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_next_num  <= NUMBER_BITS'(1);
            r_tail      <= '0;
            r_live      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_next_num  <= n_next_num;
            r_tail      <= n_tail;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_richest  <= n_richest;
        r_amount   <= n_amount;
        r_cand_vld <= n_cand_vld;
        r_cand_idx <= n_cand_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    `FRQ_ASSERT_IMP(a_count_matches_marks, 1'b1, $countones(r_valid) == int'(r_count), "fill count differs from valid marks")
    `FRQ_ASSERT_IMP(a_alloc_not_full, r_state == S_ALLOC, r_count < CNT_W'(CAPACITY), "slot search on a full table")
    `FRQ_ASSERT_IMP(a_serve_has_best, r_state == S_SERVE, best.found && r_valid[best.slot], "serve without a valid candidate")
    `FRQ_ASSERT_NXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready, "second item taken while busy")

endmodule

### verif/tb_fifo_and_richest_first_queue.sv
// Self-checking bench for the waiting table with oldest-first and richest-first service.
// Drives request items, predicts every status item and compares them field by field.
// Depends on: frq_pkg, fifo_and_richest_first_queue.
module tb_fifo_and_richest_first_queue;
    import frq_pkg::*;

    // Request code that the block does not use: it changes nothing
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 540;
    localparam int SETTLE_CYCLES  = CAPACITY + 40;
    localparam int WATCHDOG_LIMIT = 10 * (CAPACITY + 40);

    typedef struct {
        t_in_item item;
        bit       drain;  // hold this item back until every result is in
        bit       calm;   // from this item on, no more idle bursts
    } t_pending;

    logic      i_clk    = 1'b0;
    logic      i_rst_n  = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item  = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_pending  pending_requests [$];
    t_out_item awaited_status [$];

    // Predictor copy of the waiting table
    bit        slot_used   [CAPACITY];
    t_amt      slot_amount [CAPACITY];
    t_num      slot_number [CAPACITY];
    t_num      issue_number = t_num'(1);
    int        alloc_start  = 0;
    int        held_count   = 0;

    bit        bursts_on    = 1'b1;
    int        send_gap     = 0;
    int        stall_left   = 0;
    int        quiet_cycles = 0;
    int        n_fail       = 0;
    int        n_checked    = 0;
    int        status_seen [4];

    fifo_and_richest_first_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    always #1 i_clk = ~i_clk;

    // Works out the status item for one request and updates the table copy
    function automatic t_out_item table_outcome(t_in_item req);
        t_out_item res;
        int        slot;
        int        best;
        res.status        = ST_EMPTY;
        res.served_number = '0;
        case (req.req_type)
            REQ_ARRIVE: begin
                if (held_count < CAPACITY && issue_number != '0) begin
                    slot = alloc_start;
                    while (slot_used[slot]) slot = (slot + 1) % CAPACITY;
                    slot_used[slot]   = 1'b1;
                    slot_amount[slot] = req.amount;
                    slot_number[slot] = issue_number;
                    res.status        = ST_STORED;
                    res.served_number = OUT_W'(issue_number);
                    issue_number      = issue_number + NUMBER_BITS'(1);
                    alloc_start       = (slot + 1) % CAPACITY;
                    held_count++;
                end else begin
                    res.status = ST_REFUSED;
                end
            end
            REQ_OLDEST, REQ_RICHEST: begin
                best = -1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (slot_used[i]) begin
                        if (best < 0) begin
                            best = i;
                        end else if (req.req_type == REQ_RICHEST) begin
                            // largest amount wins, the older one on a tie
                            if (slot_amount[i] > slot_amount[best] ||
                                (slot_amount[i] == slot_amount[best] &&
                                 slot_number[i] < slot_number[best]))
                                best = i;
                        end else if (slot_number[i] < slot_number[best]) begin
                            best = i;
                        end
                    end
                end
                if (best >= 0) begin
                    slot_used[best]   = 1'b0;
                    res.status        = ST_SERVED;
                    res.served_number = OUT_W'(slot_number[best]);
                    held_count--;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly extremes and tiny values so that ties on the amount are common
    function automatic t_amt pick_amount();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return t_amt'($urandom_range(0, 7));
            default: return t_amt'($urandom);
        endcase
    endfunction

    task automatic queue_request(logic [1:0] kind, t_amt amt, bit drain, bit calm);
        t_pending p;
        p.item.req_type = kind;
        p.item.amount   = amt;
        p.drain         = drain;
        p.calm          = calm;
        pending_requests.push_back(p);
    endtask

    // Driver: presents request items, predicting each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                awaited_status.push_back(table_outcome(in_item));
            if (in_valid && !in_ready) begin
                // item held until the block takes it
            end else if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_requests.size() == 0 ||
                         (pending_requests[0].drain && awaited_status.size() != 0)) begin
                in_valid <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 15);
                in_valid <= 1'b0;
            end else begin
                if (pending_requests[0].calm) bursts_on = 1'b0;
                in_item  <= pending_requests[0].item;
                in_valid <= 1'b1;
                void'(pending_requests.pop_front());
            end
        end
    end

    // Monitor: checks each status item against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (awaited_status.size() == 0) begin
                    $error("result with none awaited: status %0d, served_number %0d",
                           out_item.status, out_item.served_number);
                    n_fail++;
                end else begin
                    want = awaited_status.pop_front();
                    n_checked++;
                    status_seen[want.status]++;
                    if (out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, out_item.status);
                        n_fail++;
                    end
                    if (out_item.served_number !== want.served_number) begin
                        $error("served_number: expected %0d, got %0d",
                               want.served_number, out_item.served_number);
                        n_fail++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Cycles since the last item moved on either channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        bit         timed_out;
        int         arrive_weight;
        logic [1:0] kind;
        timed_out     = 1'b0;
        arrive_weight = 5;

        // Directed: empty table, extreme amounts, a tie on the largest amount
        queue_request(REQ_OLDEST,  24'hFFFFFF, 1'b0, 1'b0);
        queue_request(REQ_RICHEST, 24'h000000, 1'b0, 1'b0);
        queue_request(REQ_UNUSED,  24'hFFFFFF, 1'b0, 1'b0);
        queue_request(REQ_ARRIVE,  24'h000000, 1'b0, 1'b0);
        queue_request(REQ_ARRIVE,  24'hFFFFFF, 1'b0, 1'b0);
        queue_request(REQ_ARRIVE,  24'hAAAAAA, 1'b0, 1'b0);
        queue_request(REQ_ARRIVE,  24'h555555, 1'b0, 1'b0);
        queue_request(REQ_ARRIVE,  24'hFFFFFF, 1'b0, 1'b0);
        queue_request(REQ_ARRIVE,  24'h000000, 1'b0, 1'b0);
        queue_request(REQ_UNUSED,  24'h123456, 1'b0, 1'b0);
        queue_request(REQ_RICHEST, 24'h000000, 1'b0, 1'b0);
        queue_request(REQ_RICHEST, 24'hFFFFFF, 1'b0, 1'b0);
        queue_request(REQ_OLDEST,  24'h000000, 1'b0, 1'b0);
        queue_request(REQ_RICHEST, 24'hAAAAAA, 1'b0, 1'b0);
        queue_request(REQ_OLDEST,  24'h555555, 1'b0, 1'b0);
        queue_request(REQ_RICHEST, 24'h000000, 1'b0, 1'b0);
        queue_request(REQ_OLDEST,  24'hFFFFFF, 1'b0, 1'b0);
        queue_request(REQ_RICHEST, 24'hFFFFFF, 1'b0, 1'b0);

        // Fill to capacity after a full drain, then two refused arrivals
        for (int i = 0; i < CAPACITY; i++)
            queue_request(REQ_ARRIVE, pick_amount(), i == 0, 1'b0);
        queue_request(REQ_ARRIVE, 24'hFFFFFF, 1'b0, 1'b0);
        queue_request(REQ_ARRIVE, 24'h000000, 1'b0, 1'b0);

        // Punch holes with both orders, then refill: the free-slot search wraps
        for (int i = 0; i < 20; i++)
            queue_request(i[0] ? REQ_RICHEST : REQ_OLDEST, pick_amount(), 1'b0, 1'b0);
        for (int i = 0; i < 10; i++)
            queue_request(REQ_ARRIVE, pick_amount(), 1'b0, 1'b0);

        // Random mix, with the arrival share changing every few dozen items
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 45 == 0) arrive_weight = $urandom_range(2, 8);
            if ($urandom_range(0, 19) == 0)
                kind = REQ_UNUSED;
            else if ($urandom_range(0, 9) < arrive_weight)
                kind = REQ_ARRIVE;
            else
                kind = $urandom_range(0, 1) ? REQ_RICHEST : REQ_OLDEST;
            queue_request(kind, pick_amount(), i == RANDOM_ITEMS / 2, i == RANDOM_ITEMS - 80);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                while (pending_requests.size() != 0 || in_valid ||
                       awaited_status.size() != 0)
                    @(posedge i_clk);
                repeat (SETTLE_CYCLES) @(posedge i_clk);
            end
            begin
                while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
                timed_out = 1'b1;
            end
        join_any
        disable fork;

        if (timed_out)
            $display("no item moved for %0d cycles, %0d results still awaited",
                     WATCHDOG_LIMIT, awaited_status.size());
        $display("checked %0d results: %0d stored, %0d served, %0d empty, %0d refused",
                 n_checked, status_seen[ST_STORED], status_seen[ST_SERVED],
                 status_seen[ST_EMPTY], status_seen[ST_REFUSED]);
        $display("table filled to capacity, served in both orders, %0d mismatches", n_fail);
        if (!timed_out && n_fail == 0)
            $display("tb_fifo_and_richest_first_queue OK");
        else
            $display("tb_fifo_and_richest_first_queue NOT OK");
        $finish;
    end

endmodule

### fifo_and_richest_first_queue.f
+incdir+sv
sv/frq_pkg.sv
sv/frq_ram.sv
sv/frq_best.sv
sv/fifo_and_richest_first_queue.sv
verif/tb_fifo_and_richest_first_queue.sv
